### src/brq_pkg.sv
// Shared constants, types and helpers for the byte ring queue.
`default_nettype none
package brq_pkg;

    localparam int DEPTH    = 1024;
    localparam int RESERVED = 1;
    localparam int MAX_XFER = 8;

    localparam int LANES    = 8;
    localparam int LANE_W   = 3;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int ROWS     = DEPTH / LANES;
    localparam int ROW_W    = PTR_W - LANE_W;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CAP      = DEPTH - RESERVED;
    localparam int REP_W    = 10;
    localparam int LEN_W    = 4;
    localparam int DATA_W   = 64;
    localparam int CMD_W    = 2;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;
    localparam int Q_CNT_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT  = 2'd0,
        CMD_GET  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_BAD  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic              ok;
        logic              wr;
        logic              rd;
        logic [LEN_W-1:0]  len;
        logic [PTR_W-1:0]  ptr;
        logic [DATA_W-1:0] data;
        logic [REP_W-1:0]  used;
        logic [REP_W-1:0]  free;
    } t_op;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr,
                                                     input logic [LEN_W-1:0] len);
        logic [PTR_W:0] sum;
        sum = {1'b0, ptr} + (PTR_W+1)'(len);
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [REP_W-1:0] report(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+REP_W-1:0] ext;
        ext = {{REP_W{1'b0}}, cnt};
        return ext[REP_W-1:0];
    endfunction

endpackage
`default_nettype wire

### src/brq_ifs.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface brq_in_if;
    logic                         valid;
    logic                         ready;
    logic [brq_pkg::CMD_W-1:0]    command;
    logic [brq_pkg::LEN_W-1:0]    length;
    logic [brq_pkg::DATA_W-1:0]   write_bytes;

    modport source (output valid, command, length, write_bytes, input ready);
    modport sink   (input valid, command, length, write_bytes, output ready);
endinterface

interface brq_out_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [brq_pkg::DATA_W-1:0]   read_bytes;
    logic [brq_pkg::REP_W-1:0]    used_count;
    logic [brq_pkg::REP_W-1:0]    free_count;

    modport source (output valid, ok, read_bytes, used_count, free_count, input ready);
    modport sink   (input valid, ok, read_bytes, used_count, free_count, output ready);
endinterface
`default_nettype wire

### src/byte_ring_queue.sv
// Byte ring queue top level: front end, operation queue and banked storage back end.
//
// Request channel i_in carries command (put, get, peek), length (0..8 bytes)
// and write_bytes (first byte in the low bits). Response channel o_out returns
// one transaction per request: ok, read_bytes (zero past the length, and zero
// for puts and refusals), and the used and free byte counts after the request.
// Both channels transfer on a cycle where valid and ready are high.
// A request passes through a queue slot, the storage access and the response
// register, in that order, before its response is valid.
// Throughput: one request per cycle while the queue has space; each byte lane is
// one memory bank with a single port, and a request touches each lane at most once.
// The front end decides every request on arrival and runs ahead of storage by
// up to four queued requests plus two back-end stages.
// Reset clears pointers, counts and all valid flags; stored bytes keep their
// old contents and are never returned before being put again.
// When the receiver holds ready low, the response holds, the back end stops,
// the queue fills, and then i_in.ready drops until space frees up.
`default_nettype none
module byte_ring_queue (
    input  wire         i_clk,
    input  wire         i_rst_n,
    brq_in_if.sink      i_in,
    brq_out_if.source   o_out
);

    brq_pkg::t_op front_op;
    brq_pkg::t_op q_op;
    logic         front_valid;
    logic         q_ready;
    logic         q_valid;
    logic         q_pop;

    brq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_valid (front_valid),
        .o_op      (front_op)
    );

    brq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_op    (front_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_op    (q_op)
    );

    brq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (q_op),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

### src/brq_front.sv
// Request front end: admission checks, pointer and count bookkeeping.
`default_nettype none
module brq_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    brq_in_if.sink           i_in,
    input  wire              i_q_ready,
    output logic             o_q_valid,
    output brq_pkg::t_op     o_op
);

    logic [brq_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [brq_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [brq_pkg::CNT_W-1:0] r_held, n_held;
    logic [brq_pkg::CNT_W-1:0] free_now;
    logic [brq_pkg::CNT_W-1:0] len_ext;
    logic                      len_ok;
    logic                      put_ok;
    logic                      take_ok;
    logic                      is_get;
    logic                      accept;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign o_q_valid  = i_in.valid;

    always_comb begin
        free_now = brq_pkg::CNT_W'(brq_pkg::CAP) - r_held;
        len_ext  = brq_pkg::CNT_W'(i_in.length);
        len_ok   = i_in.length <= brq_pkg::LEN_W'(brq_pkg::MAX_XFER);
        put_ok   = len_ok && (i_in.command == brq_pkg::CMD_PUT) && (len_ext <= free_now);
        is_get   = i_in.command == brq_pkg::CMD_GET;
        take_ok  = len_ok && (is_get || (i_in.command == brq_pkg::CMD_PEEK))
                   && (len_ext <= r_held);

        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_held   = r_held;
        if (put_ok) begin
            n_wr_ptr = brq_pkg::ptr_advance(r_wr_ptr, i_in.length);
            n_held   = r_held + len_ext;
        end else if (take_ok && is_get) begin
            n_rd_ptr = brq_pkg::ptr_advance(r_rd_ptr, i_in.length);
            n_held   = r_held - len_ext;
        end

        o_op.ok   = put_ok || take_ok;
        o_op.wr   = put_ok;
        o_op.rd   = take_ok;
        o_op.len  = i_in.length;
        o_op.ptr  = put_ok ? r_wr_ptr : r_rd_ptr;
        o_op.data = i_in.write_bytes;
        o_op.used = brq_pkg::report(n_held);
        o_op.free = brq_pkg::report(brq_pkg::CNT_W'(brq_pkg::CAP) - n_held);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_held   <= '0;
        end else if (accept) begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_held   <= n_held;
        end
    end

endmodule
`default_nettype wire

### src/brq_fifo.sv
// Short operation queue between the front end and the storage back end.
`default_nettype none
module brq_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  brq_pkg::t_op     i_op,
    output logic             o_ready,
    output logic             o_valid,
    input  wire              i_pop,
    output brq_pkg::t_op     o_op
);

    brq_pkg::t_op                r_ent [brq_pkg::Q_DEPTH];
    logic [brq_pkg::Q_PTR_W-1:0] r_wp;
    logic [brq_pkg::Q_PTR_W-1:0] r_rp;
    logic [brq_pkg::Q_CNT_W-1:0] r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_ready = r_cnt != brq_pkg::Q_CNT_W'(brq_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_op    = r_ent[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### src/brq_back.sv
// Storage back end: eight banked byte lanes, read alignment and response register.
`default_nettype none
module brq_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_valid,
    input  brq_pkg::t_op     i_op,
    output logic             o_pop,
    brq_out_if.source        o_out
);

    logic                       r_s1_valid;
    brq_pkg::t_op               r_s1_op;
    logic [7:0]                 r_rdata [brq_pkg::LANES];
    logic                       s1_adv;
    logic                       out_free;
    logic [brq_pkg::ROW_W-1:0]  ptr_row;
    logic [brq_pkg::ROW_W-1:0]  next_row;
    logic [brq_pkg::LANE_W-1:0] ptr_lane;
    logic [brq_pkg::DATA_W-1:0] n_read_bytes;

    logic                       r_out_valid;
    logic                       r_ok;
    logic [brq_pkg::DATA_W-1:0] r_read_bytes;
    logic [brq_pkg::REP_W-1:0]  r_used;
    logic [brq_pkg::REP_W-1:0]  r_free;

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_pop    = i_q_valid && (!r_s1_valid || out_free);

    assign ptr_lane = i_op.ptr[brq_pkg::LANE_W-1:0];
    assign ptr_row  = i_op.ptr[brq_pkg::PTR_W-1:brq_pkg::LANE_W];
    assign next_row = (ptr_row == brq_pkg::ROW_W'(brq_pkg::ROWS - 1)) ? '0 : ptr_row + 1'b1;

    for (genvar b = 0; b < brq_pkg::LANES; b++) begin : g_lane
        logic [7:0]                 mem [brq_pkg::ROWS];
        logic [brq_pkg::LANE_W-1:0] idx;
        logic [brq_pkg::ROW_W-1:0]  row;
        logic                       we;

        assign idx = brq_pkg::LANE_W'(b) - ptr_lane;
        assign row = (brq_pkg::LANE_W'(b) < ptr_lane) ? next_row : ptr_row;
        assign we  = o_pop && i_op.wr
                     && ({1'b0, idx} < i_op.len[brq_pkg::LANE_W:0] || i_op.len[brq_pkg::LEN_W-1]);

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[row] <= i_op.data[{idx, 3'b000} +: 8];
            end
            if (o_pop && i_op.rd) begin
                r_rdata[b] <= mem[row];
            end
        end
    end

    always_comb begin
        n_read_bytes = '0;
        for (int i = 0; i < brq_pkg::LANES; i++) begin
            if (r_s1_op.rd && (brq_pkg::LEN_W'(i) < r_s1_op.len)) begin
                n_read_bytes[8*i +: 8] =
                    r_rdata[brq_pkg::LANE_W'(r_s1_op.ptr[brq_pkg::LANE_W-1:0]
                                             + brq_pkg::LANE_W'(i))];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_op <= i_op;
        end
        if (s1_adv) begin
            r_ok         <= r_s1_op.ok;
            r_read_bytes <= n_read_bytes;
            r_used       <= r_s1_op.used;
            r_free       <= r_s1_op.free;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.ok         = r_ok;
    assign o_out.read_bytes = r_read_bytes;
    assign o_out.used_count = r_used;
    assign o_out.free_count = r_free;

endmodule
`default_nettype wire

### src/brq_checker.sv
// Port-level assertions for the byte ring queue, bound to the top level.
`default_nettype none
module brq_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire                          i_out_ok,
    input wire [brq_pkg::DATA_W-1:0]    i_out_read_bytes,
    input wire [brq_pkg::REP_W-1:0]     i_out_used,
    input wire [brq_pkg::REP_W-1:0]     i_out_free
);

    localparam logic [brq_pkg::REP_W-1:0] CapRep = brq_pkg::REP_W'(brq_pkg::CAP);

    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (brq_pkg::REP_W'(i_out_used + i_out_free) == CapRep))
        else $error("used and free counts do not add up to capacity");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ok) |-> (i_out_read_bytes == '0))
        else $error("refused transaction returned data");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_read_bytes) && $stable(i_out_used)))
        else $error("stalled response changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid right after reset");

endmodule

bind byte_ring_queue brq_checker u_brq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_ok         (o_out.ok),
    .i_out_read_bytes (o_out.read_bytes),
    .i_out_used       (o_out.used_count),
    .i_out_free       (o_out.free_count)
);
`default_nettype wire

### test/tb_byte_ring_queue.sv
// Testbench for byte_ring_queue: directed and random put/get/peek/bad traffic checked against a scoreboard.
`timescale 1ns / 100ps

module tb_byte_ring_queue;
    import brq_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYCS  = 8;
    localparam int CHUNK_ITEMS = 150;
    localparam int NUM_CHUNKS  = 8;
    localparam int SETTLE_CYCS = 12;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] read_bytes;
        logic [REP_W-1:0]  used_count;
        logic [REP_W-1:0]  free_count;
    } queue_result_t;

    class queue_scoreboard;
        logic [7:0]    slot_data [DEPTH];
        int unsigned   head_slot;
        int unsigned   tail_slot;
        int unsigned   fill_level;
        queue_result_t outstanding [$];
        int            errors;

        function new();
            head_slot  = 0;
            tail_slot  = 0;
            fill_level = 0;
            errors     = 0;
        endfunction

        function int pending();
            return outstanding.size();
        endfunction

        function void note_request(t_cmd cmd, logic [LEN_W-1:0] len, logic [DATA_W-1:0] data);
            queue_result_t res;
            int unsigned   slot;
            res.ok         = 1'b0;
            res.read_bytes = '0;
            if (len <= MAX_XFER) begin
                case (cmd)
                    CMD_PUT: begin
                        if (len <= CAP - fill_level) begin
                            for (int i = 0; i < len; i++) begin
                                slot_data[tail_slot] = data[8*i +: 8];
                                tail_slot = (tail_slot + 1) % DEPTH;
                            end
                            fill_level += len;
                            res.ok = 1'b1;
                        end
                    end
                    CMD_GET, CMD_PEEK: begin
                        if (len <= fill_level) begin
                            slot = head_slot;
                            for (int i = 0; i < len; i++) begin
                                res.read_bytes[8*i +: 8] = slot_data[slot];
                                slot = (slot + 1) % DEPTH;
                            end
                            if (cmd == CMD_GET) begin
                                head_slot = slot;
                                fill_level -= len;
                            end
                            res.ok = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            res.used_count = REP_W'(fill_level);
            res.free_count = REP_W'(CAP - fill_level);
            outstanding.push_back(res);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_response(logic ok, logic [DATA_W-1:0] rd,
                            logic [REP_W-1:0] used, logic [REP_W-1:0] free);
            queue_result_t exp;
            if (outstanding.size() == 0) begin
                report("response with no request outstanding");
            end else begin
                exp = outstanding.pop_front();
                if (ok !== exp.ok)
                    report($sformatf("ok %b, want %b", ok, exp.ok));
                if (rd !== exp.read_bytes)
                    report($sformatf("read_bytes %h, want %h", rd, exp.read_bytes));
                if (used !== exp.used_count)
                    report($sformatf("used_count %0d, want %0d", used, exp.used_count));
                if (free !== exp.free_count)
                    report($sformatf("free_count %0d, want %0d", free, exp.free_count));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cycle_count;

    queue_scoreboard sb = new();

    brq_in_if  in_ch ();
    brq_out_if out_ch ();

    byte_ring_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    initial out_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_response(out_ch.ok, out_ch.read_bytes, out_ch.used_count,
                              out_ch.free_count);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[byte_ring_queue] ERROR");
        $finish;
    end

    task automatic send_request(input t_cmd cmd, input logic [LEN_W-1:0] len,
                                input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.length      <= len;
        in_ch.write_bytes <= data;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(cmd, len, data);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_random(input int put_pct);
        t_cmd              cmd;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        data = {$urandom, $urandom};
        if ($urandom_range(15) == 0) begin
            cmd = t_cmd'($urandom_range(3));
            len = LEN_W'($urandom_range(15));
        end else begin
            if ($urandom_range(99) < put_pct)
                cmd = CMD_PUT;
            else if ($urandom_range(3) == 0)
                cmd = CMD_PEEK;
            else
                cmd = CMD_GET;
            len = $urandom_range(1) ? LEN_W'(MAX_XFER) : LEN_W'($urandom_range(MAX_XFER));
        end
        send_request(cmd, len, data);
    endtask

    int put_bias [NUM_CHUNKS] = '{95, 95, 5, 5, 50, 95, 95, 5};

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_PUT;
        in_ch.length      = '0;
        in_ch.write_bytes = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        repeat (RESET_CYCS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_GET,  4'd0,  64'h0);
        send_request(CMD_GET,  4'd1,  64'h0);
        send_request(CMD_PEEK, 4'd1,  64'h0);
        send_request(CMD_PUT,  4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_BAD,  4'd4,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_PUT,  4'd9,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_PUT,  4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_PUT,  4'd8,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_PUT,  4'd8,  64'h0);
        send_request(CMD_PEEK, 4'd8,  64'h0);
        send_request(CMD_GET,  4'd3,  64'h0);
        send_request(CMD_PEEK, 4'd0,  64'h0);
        send_request(CMD_GET,  4'd9,  64'h0);
        send_request(CMD_PEEK, 4'd15, 64'h0);
        send_request(CMD_PUT,  4'd1,  64'hFFFF_FFFF_FFFF_FFA5);
        send_request(CMD_PUT,  4'd8,  64'h0123_4567_89AB_CDEF);
        send_request(CMD_PEEK, 4'd8,  64'h0);
        send_request(CMD_GET,  4'd8,  64'h0);
        send_request(CMD_GET,  4'd8,  64'h0);
        send_request(CMD_GET,  4'd8,  64'h0);
        send_request(CMD_BAD,  4'd15, 64'h0);
        send_request(CMD_BAD,  4'd0,  64'h0);
        wait_drained();

        for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
            case (chunk % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int n = 0; n < CHUNK_ITEMS; n++)
                send_random(put_bias[chunk]);
            wait_drained();
        end

        repeat (SETTLE_CYCS) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[byte_ring_queue] OK");
        else
            $display("[byte_ring_queue] ERROR");
        $finish;
    end

endmodule
